[rtl/tcse_pkg.sv]
// Shared constants and types for the tone curve spline evaluator.
// Used by the top level and by the pipelined divider; depends on nothing.
package tcse_pkg;

  // Point table geometry.
  localparam int MAX_POINTS = 16;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int KNOT_W     = 16;
  localparam int CNT_W      = 5;
  localparam int SMP_W      = 20;

  // Reset value and limits of the point count register.
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd2;
  localparam logic [CNT_W-1:0] CNT_MIN   = 5'd2;
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_POINTS);

  // Gap floor and flat-segment limit, in LSB.
  localparam int GAP_FLOOR  = 7;
  localparam int FLAT_LIMIT = 7;

  // Pipelined divider: dividend bits, divisor bits, quotient bits per stage.
  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

  // Command codes carried in the input tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Where the sample falls relative to the control points.
  typedef enum logic [2:0] {
    MODE_INSIDE = 3'b001,
    MODE_LEFT   = 3'b010,
    MODE_RIGHT  = 3'b100
  } mode_t;

endpackage

[rtl/tcse_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module tcse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tcse_div.sv]
// Pipelined unsigned restoring divider, four quotient bits per stage.
// Depends on tcse_pkg for the widths and the stage count.
module tcse_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tcse_pkg::DIV_NUM_W-1:0] num,
  input  logic [tcse_pkg::DIV_DEN_W-1:0] den,
  output logic [tcse_pkg::DIV_NUM_W-1:0] quo
);
  import tcse_pkg::*;

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_NUM_W-1:0] work;
  } div_state_t;

  // Shift the dividend out of the top of work; quotient bits enter at the bottom.
  function automatic div_state_t div_step(input logic [DIV_NUM_W-1:0] w,
                                          input logic [DIV_DEN_W-1:0] r,
                                          input logic [DIV_DEN_W-1:0] d);
    div_state_t st;
    logic [DIV_DEN_W:0] t;
    st.work = w;
    st.rem  = r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t       = {st.rem, st.work[DIV_NUM_W-1]};
      st.work = {st.work[DIV_NUM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        st.rem     = DIV_DEN_W'(t - {1'b0, d});
        st.work[0] = 1'b1;
      end else begin
        st.rem = t[DIV_DEN_W-1:0];
      end
    end
    return st;
  endfunction

  div_state_t           stg [DIV_STAGES];
  logic [DIV_DEN_W-1:0] dn  [DIV_STAGES];

  // Each stage retires DIV_STEPS quotient bits and passes the divisor along.
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= div_step(num, '0, den);
      dn[0]  <= den;
      for (int s = 1; s < DIV_STAGES; s++) begin
        stg[s] <= div_step(stg[s-1].work, stg[s-1].rem, dn[s-1]);
        dn[s]  <= dn[s-1];
      end
    end
  end

  assign quo = stg[DIV_STAGES-1].work;

endmodule

[rtl/tone_curve_spline_eval.sv]
// Top level of the tone curve spline evaluator: point table, segment search,
// slope division, Hermite blend and saturation. Uses tcse_pkg, tcse_ram, tcse_div.
//
//   channel | signals                         | carries
//   --------+---------------------------------+--------------------------------------
//   config  | cfg_wr_en, cfg_wr_data          | point_count
//   input   | s_tvalid/s_tready/s_tdata/tuser | command, point index, x, y, sample
//   output  | m_tvalid/m_tready/m_tdata/tuser | mapped value, saturated flag
//
// One transaction is accepted every clock while the pipeline is not held; a result
// passes through the input register, the table read, the ten-stage slope divider
// and the multiply and rounding stages around it. Point writes give no result.
// Reset (rst, synchronous) clears the valid bits and sets point_count to 2.
// The whole pipeline holds when the output register is full and not taken.
module tone_curve_spline_eval (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [tcse_pkg::CNT_W-1:0] cfg_wr_data,  // point_count
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [55:0]                s_tdata,      // point_index, point_x, point_y, sample
  input  logic [0:0]                 s_tuser,      // command
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,      // mapped, zero fill
  output logic [0:0]                 m_tuser       // saturated
);
  import tcse_pkg::*;

  localparam int NUM_W = 37;
  localparam int R_W   = 40;
  localparam int NPOST = 7;
  localparam int NV    = 2 + DIV_STAGES + NPOST;

  typedef struct packed {
    logic [3:0]           neg;
    mode_t                mode;
    logic                 degen;
    logic [KNOT_W-1:0]    ya;
    logic [KNOT_W-1:0]    yb;
    logic signed [16:0]   ybase;
    logic signed [16:0]   dx;
  } side_t;

  typedef struct packed {
    mode_t                mode;
    logic                 degen;
    logic [KNOT_W-1:0]    ya;
    logic [KNOT_W-1:0]    yb;
    logic signed [R_W-1:0] ye;
    logic signed [16:0]   dx;
    logic signed [35:0]   m0;
    logic signed [35:0]   m1;
    logic [16:0]          u;
    logic [33:0]          u2;
    logic signed [52:0]   pt0;
    logic signed [52:0]   pt1;
    logic signed [21:0]   t0;
    logic signed [21:0]   t1;
    logic [50:0]          u3raw;
    logic [33:0]          u3;
    logic signed [36:0]   h00;
    logic signed [36:0]   h10;
    logic signed [36:0]   h01;
    logic signed [36:0]   h11;
    logic signed [58:0]   k00;
    logic signed [58:0]   k10;
    logic signed [58:0]   k01;
    logic signed [58:0]   k11;
    logic signed [60:0]   acc;
  } post_t;

  function automatic logic [DIV_DEN_W-1:0] floor_gap(input logic signed [16:0] g);
    return (g < 17'sd7) ? DIV_DEN_W'(GAP_FLOOR) : g[15:0];
  endfunction

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Configuration register.
  logic [CNT_W-1:0] point_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_RESET;
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  logic [CNT_W-1:0] n_eff, nm1, nm2;
  always_comb begin
    if (point_count < CNT_MIN) begin
      n_eff = CNT_MIN;
    end else if (point_count > CNT_MAX) begin
      n_eff = CNT_MAX;
    end else begin
      n_eff = point_count;
    end
    nm1 = n_eff - 5'd1;
    nm2 = n_eff - 5'd2;
  end

  // Input register.
  logic                     s0_valid;
  logic                     s0_cmd;
  logic [PT_AW-1:0]         s0_idx;
  logic [KNOT_W-1:0]        s0_x, s0_y;
  logic signed [SMP_W-1:0]  s0_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_cmd <= s_tuser[0];
      s0_idx <= s_tdata[PT_AW-1:0];
      s0_x   <= s_tdata[19:4];
      s0_y   <= s_tdata[35:20];
      s0_v   <= s_tdata[55:36];
    end
  end

  // Flip-flop copy of the x table for the comparator bank.
  logic [KNOT_W-1:0] knot_x [MAX_POINTS];
  logic              wr_pt;
  assign wr_pt = en && s0_valid && (s0_cmd == CMD_WRITE);
  always_ff @(posedge clk) begin
    if (wr_pt) begin
      knot_x[s0_idx] <= s0_x;
    end
  end

  // Segment search and table addresses.
  logic [MAX_POINTS-1:0] ltv, gtv;
  logic [PT_AW-1:0]      seg, ad_a, ad_b, ad_p, ad_q;
  mode_t                 mode0;
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      ltv[i] = s0_v < $signed({4'b0, knot_x[i]});
      gtv[i] = s0_v > $signed({4'b0, knot_x[i]});
    end
    seg = nm2[PT_AW-1:0];
    for (int i = MAX_POINTS - 2; i >= 0; i--) begin
      if ((CNT_W'(i) <= nm2) && ltv[i+1]) begin
        seg = PT_AW'(i);
      end
    end
    if (ltv[0]) begin
      mode0 = MODE_LEFT;
    end else if (gtv[nm1[PT_AW-1:0]]) begin
      mode0 = MODE_RIGHT;
    end else begin
      mode0 = MODE_INSIDE;
    end
    case (mode0)
      MODE_LEFT: begin
        ad_a = '0;
        ad_b = PT_AW'(1);
        ad_p = '0;
        ad_q = PT_AW'(1);
      end
      MODE_RIGHT: begin
        ad_a = nm2[PT_AW-1:0];
        ad_b = nm1[PT_AW-1:0];
        ad_p = nm2[PT_AW-1:0];
        ad_q = nm1[PT_AW-1:0];
      end
      default: begin
        ad_a = seg;
        ad_b = seg + PT_AW'(1);
        ad_p = (seg == '0) ? '0 : seg - PT_AW'(1);
        ad_q = ((CNT_W'(seg) + 5'd2) < nm1) ? seg + PT_AW'(2) : nm1[PT_AW-1:0];
      end
    endcase
  end

  // Four copies of the {y, x} table, one read port each.
  logic [2*KNOT_W-1:0] rd_a, rd_b, rd_p, rd_q;
  tcse_ram #(.WIDTH(2*KNOT_W), .DEPTH(MAX_POINTS)) u_ram_a (
    .clk(clk), .we(wr_pt), .waddr(s0_idx), .wdata({s0_y, s0_x}),
    .re(en), .raddr(ad_a), .rdata(rd_a));
  tcse_ram #(.WIDTH(2*KNOT_W), .DEPTH(MAX_POINTS)) u_ram_b (
    .clk(clk), .we(wr_pt), .waddr(s0_idx), .wdata({s0_y, s0_x}),
    .re(en), .raddr(ad_b), .rdata(rd_b));
  tcse_ram #(.WIDTH(2*KNOT_W), .DEPTH(MAX_POINTS)) u_ram_p (
    .clk(clk), .we(wr_pt), .waddr(s0_idx), .wdata({s0_y, s0_x}),
    .re(en), .raddr(ad_p), .rdata(rd_p));
  tcse_ram #(.WIDTH(2*KNOT_W), .DEPTH(MAX_POINTS)) u_ram_q (
    .clk(clk), .we(wr_pt), .waddr(s0_idx), .wdata({s0_y, s0_x}),
    .re(en), .raddr(ad_q), .rdata(rd_q));

  // Valid bits of every stage after the input register; only evaluations enter.
  logic [NV-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], s0_valid && (s0_cmd == CMD_EVAL)};
    end
  end

  // Stage 1: side data alongside the table read.
  mode_t                   s1_mode;
  logic signed [SMP_W-1:0] s1_v;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode <= mode0;
      s1_v    <= s0_v;
    end
  end

  // Differences, numerators and floored gaps.
  logic [KNOT_W-1:0]      xa, ya, xb, yb, xp, yp, xq, yq, xbase;
  logic signed [16:0]     dx, dyba, dyp, dyq;
  logic signed [20:0]     dv;
  logic signed [37:0]     ext_prod;
  logic signed [NUM_W-1:0] n0, n1, ns, nu;
  always_comb begin
    {ya, xa} = rd_a;
    {yb, xb} = rd_b;
    {yp, xp} = rd_p;
    {yq, xq} = rd_q;
    dx    = $signed({1'b0, xb}) - $signed({1'b0, xa});
    dyba  = $signed({1'b0, yb}) - $signed({1'b0, ya});
    dyp   = $signed({1'b0, yb}) - $signed({1'b0, yp});
    dyq   = $signed({1'b0, yq}) - $signed({1'b0, ya});
    xbase = (s1_mode == MODE_RIGHT) ? xb : xa;
    dv    = $signed({s1_v[SMP_W-1], s1_v}) - $signed({5'b0, xbase});
    ext_prod = dyba * dv;
    n0 = $signed({{4{dyp[16]}}, dyp, 16'b0});
    n1 = $signed({{4{dyq[16]}}, dyq, 16'b0});
    ns = $signed({{4{dyba[16]}}, dyba, 16'b0});
    nu = (s1_mode == MODE_INSIDE) ? $signed({dv, 16'b0}) : NUM_W'(ext_prod);
  end

  // Stage 2: numerators and divisors.
  logic signed [NUM_W-1:0] s2_num [4];
  logic [DIV_DEN_W-1:0]    s2_den [4];
  side_t                   s2_side;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_num[0] <= n0;
      s2_num[1] <= n1;
      s2_num[2] <= ns;
      s2_num[3] <= nu;
      s2_den[0] <= floor_gap($signed({1'b0, xb}) - $signed({1'b0, xp}));
      s2_den[1] <= floor_gap($signed({1'b0, xq}) - $signed({1'b0, xa}));
      s2_den[2] <= floor_gap(dx);
      s2_den[3] <= floor_gap(dx);
      s2_side.neg   <= '0;
      s2_side.mode  <= s1_mode;
      s2_side.degen <= (s1_mode == MODE_INSIDE) && (dx < 17'sd7);
      s2_side.ya    <= ya;
      s2_side.yb    <= yb;
      s2_side.ybase <= (s1_mode == MODE_RIGHT) ? $signed({1'b0, yb}) : $signed({1'b0, ya});
      s2_side.dx    <= dx;
    end
  end

  // Rounding to nearest: magnitude plus half the divisor, sign restored later.
  logic [DIV_NUM_W-1:0] dv_num [4];
  logic [DIV_NUM_W-1:0] quo    [4];
  logic [3:0]           neg2;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg2[k]   = s2_num[k][NUM_W-1];
      dv_num[k] = DIV_NUM_W'(neg2[k] ? NUM_W'(-s2_num[k]) : NUM_W'(s2_num[k]))
                + DIV_NUM_W'(s2_den[k] >> 1);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_div
    tcse_div u_div (.clk(clk), .en(en), .num(dv_num[k]), .den(s2_den[k]), .quo(quo[k]));
  end

  // Side data travels with the divider stages, with the numerator signs added.
  side_t side_in;
  always_comb begin
    side_in     = s2_side;
    side_in.neg = neg2;
  end

  side_t dside [DIV_STAGES];
  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= side_in;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dside[s] <= dside[s-1];
      end
    end
  end

  post_t p1, p2, p3, p4, p5, p6, p7;
  post_t nx1, nx2, nx3, nx4, nx5, nx6, nx7;

  // Post 1: signed slopes, ratio clamp, flat test, u clamp, extrapolated value.
  logic [34:0]            mag0, mag1, asl, lim, c0, c1;
  logic                   flat;
  logic signed [35:0]     ext_e;
  side_t                  dl;
  always_comb begin
    dl   = dside[DIV_STAGES-1];
    mag0 = 35'(quo[0][32:0]);
    mag1 = 35'(quo[1][32:0]);
    asl  = 35'(quo[2][32:0]);
    lim  = asl + (asl << 1);
    flat = asl < 35'(FLAT_LIMIT);
    c0   = (mag0 > lim) ? lim : mag0;
    c1   = (mag1 > lim) ? lim : mag1;
    ext_e = dl.neg[3] ? -$signed({1'b0, quo[3][34:0]}) : $signed({1'b0, quo[3][34:0]});
    nx1       = p1;
    nx1.mode  = dl.mode;
    nx1.degen = dl.degen;
    nx1.ya    = dl.ya;
    nx1.yb    = dl.yb;
    nx1.dx    = dl.dx;
    nx1.ye    = R_W'(dl.ybase) + R_W'(ext_e);
    if (flat) begin
      nx1.m0 = '0;
      nx1.m1 = '0;
    end else begin
      nx1.m0 = dl.neg[0] ? -$signed({1'b0, c0}) : $signed({1'b0, c0});
      nx1.m1 = dl.neg[1] ? -$signed({1'b0, c1}) : $signed({1'b0, c1});
    end
    if (dl.neg[3]) begin
      nx1.u = '0;
    end else if (quo[3] > DIV_NUM_W'(65536)) begin
      nx1.u = 17'd65536;
    end else begin
      nx1.u = quo[3][16:0];
    end
  end

  // Post 2: tangent products and u squared.
  always_comb begin
    nx2     = p1;
    nx2.pt0 = p1.dx * p1.m0;
    nx2.pt1 = p1.dx * p1.m1;
    nx2.u2  = 34'(p1.u) * 34'(p1.u);
  end

  // Post 3: tangents rounded from Q16 to integers and u cubed before rounding.
  logic [52:0] tm0, tm1;
  logic [36:0] tr0, tr1;
  always_comb begin
    tm0 = (p2.pt0 < 0) ? 53'(-p2.pt0) : 53'(p2.pt0);
    tm1 = (p2.pt1 < 0) ? 53'(-p2.pt1) : 53'(p2.pt1);
    tr0 = 37'((tm0 + 53'd32768) >> 16);
    tr1 = 37'((tm1 + 53'd32768) >> 16);
    nx3       = p2;
    nx3.t0    = (p2.pt0 < 0) ? -$signed(22'(tr0)) : $signed(22'(tr0));
    nx3.t1    = (p2.pt1 < 0) ? -$signed(22'(tr1)) : $signed(22'(tr1));
    nx3.u3raw = 51'(p2.u2) * 51'(p2.u);
  end

  // Post 4: u cubed rounded to Q32.
  always_comb begin
    nx4    = p3;
    nx4.u3 = 34'((p3.u3raw + 51'd32768) >> 16);
  end

  // Post 5: Hermite basis functions in Q32.
  logic signed [36:0] su, su2, su3;
  localparam logic signed [36:0] ONE_Q32 = 37'sh1_0000_0000;
  always_comb begin
    su3 = $signed({3'b0, p4.u3});
    su2 = $signed({3'b0, p4.u2});
    su  = $signed({4'b0, p4.u, 16'b0});
    nx5     = p4;
    nx5.h00 = (su3 <<< 1) - su2 - (su2 <<< 1) + ONE_Q32;
    nx5.h10 = su3 - (su2 <<< 1) + su;
    nx5.h01 = su2 + (su2 <<< 1) - (su3 <<< 1);
    nx5.h11 = su3 - su2;
  end

  // Post 6: weighted terms.
  always_comb begin
    nx6     = p5;
    nx6.k00 = p5.h00 * $signed({1'b0, p5.ya});
    nx6.k10 = p5.h10 * p5.t0;
    nx6.k01 = p5.h01 * $signed({1'b0, p5.yb});
    nx6.k11 = p5.h11 * p5.t1;
  end

  // Post 7: exact sum.
  always_comb begin
    nx7     = p6;
    nx7.acc = p6.k00 + p6.k10 + p6.k01 + p6.k11;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= nx1;
      p2 <= nx2;
      p3 <= nx3;
      p4 <= nx4;
      p5 <= nx5;
      p6 <= nx6;
      p7 <= nx7;
    end
  end

  // Final rounding from Q32 to an integer, choice of result and saturation.
  logic [60:0]           amag;
  logic [28:0]           arnd;
  logic signed [R_W-1:0] rsp, res, res_sat;
  logic                  sat;
  always_comb begin
    amag = (p7.acc < 0) ? 61'(-p7.acc) : 61'(p7.acc);
    arnd = 29'((amag + 61'h8000_0000) >> 32);
    rsp  = (p7.acc < 0) ? -$signed(R_W'(arnd)) : $signed(R_W'(arnd));
    if (p7.degen) begin
      res = $signed(R_W'(p7.ya));
    end else if (p7.mode != MODE_INSIDE) begin
      res = p7.ye;
    end else begin
      res = rsp;
    end
    sat     = 1'b0;
    res_sat = res;
    if (res > 40'sd524287) begin
      res_sat = 40'sd524287;
      sat     = 1'b1;
    end else if (res < -40'sd524288) begin
      res_sat = -40'sd524288;
      sat     = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[NV-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'b0, res_sat[SMP_W-1:0]};
      m_tuser <= sat;
    end
  end

endmodule
